FILE: design/vfcs_pkg.sv
package vfcs_pkg;

   localparam int CACHE_ENTRIES = 12;
   localparam int PAGE_BYTES    = 4096;
   localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);

   localparam int IDX_W   = 16;
   localparam int VSIZE_W = 11;
   localparam int PROD_W  = VSIZE_W + IDX_W;
   localparam int PAGE_W  = PROD_W - PAGE_SHIFT;
   localparam int CNT_W   = 32;
   localparam int CSR_W   = 8;

   localparam logic [CNT_W-1:0]   CNT_MAX         = {CNT_W{1'b1}};
   localparam logic [VSIZE_W-1:0] VSIZE_RESET     = VSIZE_W'(32);

   localparam logic [CSR_W-1:0]   REG_VERTEX_SIZE = CSR_W'(0);
   localparam logic [CSR_W-1:0]   REG_STRIP_MODE  = CSR_W'(1);

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + CNT_W'(1);
   endfunction

endpackage

FILE: design/vfcs_cell.sv
module vfcs_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  vfcs_pkg::cell_ctl_type     ctl,
   input  logic [vfcs_pkg::IDX_W-1:0] lookup_index,
   input  logic [vfcs_pkg::IDX_W-1:0] tag_in,
   input  logic                       valid_in,
   output logic [vfcs_pkg::IDX_W-1:0] tag_out,
   output logic                       valid_out,
   output logic                       match
);

   logic [vfcs_pkg::IDX_W-1:0] tag_ff;
   logic                       valid_ff;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctl.shift) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         tag_ff <= tag_in;
      end
   end

   assign tag_out   = tag_ff;
   assign valid_out = valid_ff;
   assign match     = valid_ff && (tag_ff == lookup_index);

endmodule

FILE: design/vfcs_row.sv
module vfcs_row (
   input  logic                       clock,
   input  logic                       reset,
   input  vfcs_pkg::cell_ctl_type     ctl,
   input  logic [vfcs_pkg::IDX_W-1:0] lookup_index,
   output logic                       hit
);

   logic [vfcs_pkg::IDX_W-1:0]        tag_chain [0:vfcs_pkg::CACHE_ENTRIES];
   logic [vfcs_pkg::CACHE_ENTRIES:0]  valid_chain;
   logic [vfcs_pkg::CACHE_ENTRIES-1:0] match;

   // new entries enter at cell 0, the oldest falls off the far end
   assign tag_chain[0]   = lookup_index;
   assign valid_chain[0] = 1'b1;

   for (genvar i = 0; i < vfcs_pkg::CACHE_ENTRIES; i++) begin : g_cell
      vfcs_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .lookup_index (lookup_index),
         .tag_in       (tag_chain[i]),
         .valid_in     (valid_chain[i]),
         .tag_out      (tag_chain[i+1]),
         .valid_out    (valid_chain[i+1]),
         .match        (match[i])
      );
   end

   assign hit = |match;

endmodule

FILE: design/vertex_fifo_cache_statistics.sv
// Vertex FIFO cache statistics.
// Request channel: req_valid / req_stall with req_vertex_index and
// req_last_of_list. One response per request on rsp_valid / rsp_stall: per-index
// hit, degenerate and page-crossing flags plus saturating running totals;
// rsp_list_done echoes last_of_list and marks the totals as final.
// The page multiply is registered with the request, then the 12-cell
// shift row does lookup and update while the response register loads.
// Throughput is one request per clock; req_stall rises only when the
// response register is full and rsp_stall holds it.
// Register port: csr_valid / csr_ready (always ready), csr_index 0 = vertex
// size, 1 = strip mode, other indexes ignored. Write only while idle.
// Reset (synchronous, active high) empties the pipeline, invalidates all
// cells, zeroes the counters, sets the page total to one, vertex size 32 and
// strip mode on. A request with last_of_list clears the list state after its
// own response is formed.
module vertex_fifo_cache_statistics (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [vfcs_pkg::IDX_W-1:0]     req_vertex_index,
   input  logic                           req_last_of_list,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_cache_hit,
   output logic                           rsp_degenerate_found,
   output logic                           rsp_page_crossed,
   output logic [vfcs_pkg::CNT_W-1:0]     rsp_hit_total,
   output logic [vfcs_pkg::CNT_W-1:0]     rsp_degenerate_total,
   output logic [vfcs_pkg::CNT_W-1:0]     rsp_pages_total,
   output logic                           rsp_list_done,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [vfcs_pkg::CSR_W-1:0]     csr_index,
   input  logic [vfcs_pkg::VSIZE_W-1:0]   csr_data
);

   logic [vfcs_pkg::VSIZE_W-1:0] vertex_size_ff;
   logic                         strip_mode_ff;

   logic                         s1_valid_ff;
   logic [vfcs_pkg::IDX_W-1:0]   s1_index_ff;
   logic                         s1_last_ff;
   logic [vfcs_pkg::PAGE_W-1:0]  s1_page_ff;

   logic [vfcs_pkg::IDX_W-1:0]   prev_index_ff, prev_index_in;
   logic [vfcs_pkg::IDX_W-1:0]   older_index_ff, older_index_in;
   logic [1:0]                   seen_ff, seen_in;
   logic [vfcs_pkg::PAGE_W-1:0]  rec_page_ff, rec_page_in;
   logic [vfcs_pkg::CNT_W-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [vfcs_pkg::CNT_W-1:0]   degen_cnt_ff, degen_cnt_in;
   logic [vfcs_pkg::CNT_W-1:0]   page_cnt_ff, page_cnt_in;

   logic                         rsp_valid_ff;
   logic                         hit_ff, degen_ff, crossed_ff, done_ff;
   logic [vfcs_pkg::CNT_W-1:0]   hit_tot_ff, degen_tot_ff, page_tot_ff;

   logic                         accept, advance, hit, degen, crossed;
   logic [vfcs_pkg::PROD_W-1:0]  product;
   logic [vfcs_pkg::PAGE_W:0]    rec_page_ext, page_plus1;
   vfcs_pkg::cell_ctl_type       cell_ctl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_size_ff <= vfcs_pkg::VSIZE_RESET;
         strip_mode_ff  <= 1'b1;
      end else if (csr_valid) begin
         if (csr_index == vfcs_pkg::REG_VERTEX_SIZE) begin
            vertex_size_ff <= csr_data;
         end else if (csr_index == vfcs_pkg::REG_STRIP_MODE) begin
            strip_mode_ff <= csr_data[0];
         end
      end
   end

   // stage 1: page of the index
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign product   = vfcs_pkg::PROD_W'(vertex_size_ff) * vfcs_pkg::PROD_W'(req_vertex_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_index_ff <= req_vertex_index;
         s1_last_ff  <= req_last_of_list;
         s1_page_ff  <= product[vfcs_pkg::PROD_W-1:vfcs_pkg::PAGE_SHIFT];
      end
   end

   // stage 2: cache row, strip and page tracking
   assign cell_ctl.shift = advance && !hit;
   assign cell_ctl.clear = advance && s1_last_ff;

   vfcs_row u_row (
      .clock        (clock),
      .reset        (reset),
      .ctl          (cell_ctl),
      .lookup_index (s1_index_ff),
      .hit          (hit)
   );

   assign rec_page_ext = {1'b0, rec_page_ff};
   assign page_plus1   = {1'b0, s1_page_ff} + (vfcs_pkg::PAGE_W+1)'(1);
   assign crossed      = (s1_page_ff > rec_page_ff) || (page_plus1 < rec_page_ext);
   assign degen        = strip_mode_ff && (seen_ff == 2'd2) &&
                         ((s1_index_ff == prev_index_ff) || (s1_index_ff == older_index_ff) ||
                          (prev_index_ff == older_index_ff));

   always_comb begin
      older_index_in = prev_index_ff;
      prev_index_in  = s1_index_ff;
      seen_in        = (seen_ff == 2'd2) ? seen_ff : seen_ff + 2'd1;
      rec_page_in    = crossed ? s1_page_ff : rec_page_ff;
      page_cnt_in    = crossed ? vfcs_pkg::sat_inc(page_cnt_ff) : page_cnt_ff;
      degen_cnt_in   = degen ? vfcs_pkg::sat_inc(degen_cnt_ff) : degen_cnt_ff;
      hit_cnt_in     = hit ? vfcs_pkg::sat_inc(hit_cnt_ff) : hit_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && s1_last_ff)) begin
         prev_index_ff  <= '0;
         older_index_ff <= '0;
         seen_ff        <= '0;
         rec_page_ff    <= '0;
         hit_cnt_ff     <= '0;
         degen_cnt_ff   <= '0;
         page_cnt_ff    <= vfcs_pkg::CNT_W'(1);
      end else if (advance) begin
         prev_index_ff  <= prev_index_in;
         older_index_ff <= older_index_in;
         seen_ff        <= seen_in;
         rec_page_ff    <= rec_page_in;
         hit_cnt_ff     <= hit_cnt_in;
         degen_cnt_ff   <= degen_cnt_in;
         page_cnt_ff    <= page_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff       <= hit;
         degen_ff     <= degen;
         crossed_ff   <= crossed;
         done_ff      <= s1_last_ff;
         hit_tot_ff   <= hit_cnt_in;
         degen_tot_ff <= degen_cnt_in;
         page_tot_ff  <= page_cnt_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_cache_hit        = hit_ff;
   assign rsp_degenerate_found = degen_ff;
   assign rsp_page_crossed     = crossed_ff;
   assign rsp_hit_total        = hit_tot_ff;
   assign rsp_degenerate_total = degen_tot_ff;
   assign rsp_pages_total      = page_tot_ff;
   assign rsp_list_done        = done_ff;

   a_stall_needs_s1 : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a full pipeline");

   a_pages_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pages_total != '0))
      else $error("page total reached zero");

   a_crossed_total : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_page_crossed) |-> (rsp_pages_total > vfcs_pkg::CNT_W'(1)))
      else $error("page crossing not reflected in total");

   a_hit_total : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cache_hit) |-> (rsp_hit_total != '0))
      else $error("hit not reflected in total");

   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff) |=> (seen_ff == 2'd0 && page_cnt_ff == vfcs_pkg::CNT_W'(1)))
      else $error("list state not cleared after last request");

endmodule
